// ===== hdl/lrmp_pkg.sv =====
// shared types, widths and modulus constants for the linear recurrence block
package lrmp_pkg;

   localparam int VAL_W = 25;
   localparam int RED_W = 26;
   localparam int MUL_W = 26;
   localparam int PROD_W = 2 * MUL_W;
   localparam int S_W = 50;
   localparam int TERM_MOD_INT = 19260817;

   // barrett reduction for products below 2^50
   localparam int BARRETT_LO = 24;
   localparam int BARRETT_HI = 26;

   typedef logic [VAL_W-1:0] term_type;

   localparam term_type TERM_MOD = VAL_W'(TERM_MOD_INT);
   localparam logic [MUL_W-1:0] BARRETT_MU = MUL_W'((64'd1 << S_W) / 64'd19260817);
   localparam logic [RED_W-1:0] TERM_MOD_X3 = RED_W'(3 * TERM_MOD_INT);

   // operands come in below twice the modulus, one subtract brings them in range
   function automatic term_type reduce_once(input term_type v);
      reduce_once = (v >= TERM_MOD) ? term_type'(v - TERM_MOD) : v;
   endfunction

endpackage

// ===== hdl/lrmp_if.sv =====
// valid/ready channel interfaces for request and response words
interface lrmp_req_if #(
   parameter int INDEX_BITS = 60
);
   import lrmp_pkg::*;

   logic                  valid;
   logic                  ready;
   term_type              coef_prev;
   term_type              coef_prev2;
   term_type              addend;
   term_type              first_term;
   term_type              second_term;
   logic [INDEX_BITS-1:0] index;

   modport source (
      output valid, coef_prev, coef_prev2, addend, first_term, second_term, index,
      input  ready
   );
   modport sink (
      input  valid, coef_prev, coef_prev2, addend, first_term, second_term, index,
      output ready
   );
endinterface

interface lrmp_rsp_if;
   import lrmp_pkg::*;

   logic     valid;
   logic     ready;
   term_type term_value;

   modport source (
      output valid, term_value,
      input  ready
   );
   modport sink (
      input  valid, term_value,
      output ready
   );
endinterface

// ===== hdl/linear_recurrence_matrix_power.sv =====
// linear recurrence term f(n) mod 19260817 by 3x3 companion matrix power
//
// Each request word gives a, b, c, f(1), f(2) and n; the response word is
// f(n) mod 19260817 for f(n) = a*f(n-1) + b*f(n-2) + c. One word is worked at
// a time and req ready is low until its result is in the output register; a
// finished result may wait there for rsp ready while the next request is taken.
// All multiplies run on one shared 26x26 multiplier, which does each modular
// multiply-add in three passes (product, barrett quotient, quotient times
// modulus), then a subtract, up to two corrections and an accumulate. Each
// matrix entry is three multiply-adds, and a 3x3 matrix product is nine
// entries. The matrices live in a 64-entry ram with two read ports.
// A request with n of 3 or more first loads the identity and the companion
// matrix into the ram, then does INDEX_BITS squarings plus one product for
// each set bit of n-2, then multiplies the top row by (f(2), f(1), 1).
// n of 0, 1 or 2 skips the matrix work and goes to the output register.
module linear_recurrence_matrix_power #(
   parameter int INDEX_BITS = 60
) (
   input  logic       clock,
   input  logic       reset,
   lrmp_req_if.sink   req_bus,
   lrmp_rsp_if.source rsp_bus
);
   import lrmp_pkg::*;

   localparam int BIT_W = $clog2(INDEX_BITS);
   localparam int RAM_DEPTH = 64;
   localparam int ADDR_W = $clog2(RAM_DEPTH);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_INIT = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_MUL  = 4'd3;
   localparam logic [3:0] S_QEST = 4'd4;
   localparam logic [3:0] S_QM   = 4'd5;
   localparam logic [3:0] S_SUB  = 4'd6;
   localparam logic [3:0] S_FIX  = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   localparam logic [1:0] MODE_SQR = 2'd0;
   localparam logic [1:0] MODE_MUL = 2'd1;
   localparam logic [1:0] MODE_VEC = 2'd2;

   // ram regions: two ping-pong banks for the running power, one for the base
   localparam logic [1:0] REG_BANK0 = 2'd0;
   localparam logic [1:0] REG_BASE  = 2'd2;

   localparam logic [1:0] IDX_LAST = 2'd2;

   logic [3:0]            state_ff, state_in;
   logic [1:0]            mode_ff, mode_in;
   logic                  bank_ff, bank_in;
   logic                  init_sel_ff, init_sel_in;
   logic [1:0]            i_ff, i_in;
   logic [1:0]            j_ff, j_in;
   logic [1:0]            k_ff, k_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [INDEX_BITS-1:0] ex_ff, ex_in;
   term_type              a_ff, a_in;
   term_type              b_ff, b_in;
   term_type              c_ff, c_in;
   term_type              f1_ff, f1_in;
   term_type              f2_ff, f2_in;
   logic [S_W-1:0]        s_ff, s_in;
   logic [MUL_W-1:0]      q_ff, q_in;
   logic [S_W-1:0]        qm_ff, qm_in;
   logic [RED_W-1:0]      r_ff, r_in;
   term_type              sum_ff, sum_in;
   logic                  out_valid_ff, out_valid_in;
   term_type              out_value_ff, out_value_in;

   logic                  req_fire;
   logic [INDEX_BITS-1:0] n_word;
   term_type              f1_red, f2_red;
   logic [MUL_W-1:0]      mul_a, mul_b;
   logic [PROD_W-1:0]     mul_p;
   term_type              rd_a, rd_b;
   term_type              y_op;
   term_type              init_val;
   logic                  r_small;
   term_type              acc_base;
   logic [RED_W-1:0]      acc_sum;
   term_type              acc_res;
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr, raddr_a, raddr_b;
   term_type              ram_wdata;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign n_word = req_bus.index;
   assign f1_red = reduce_once(req_bus.first_term);
   assign f2_red = reduce_once(req_bus.second_term);

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.term_value = out_value_ff;

   // the shared multiplier
   always_comb begin
      case (state_ff)
         S_QEST: begin
            mul_a = s_ff[S_W-1:BARRETT_LO];
            mul_b = BARRETT_MU;
         end
         S_QM: begin
            mul_a = q_ff;
            mul_b = {1'b0, TERM_MOD};
         end
         default: begin
            mul_a = {1'b0, rd_a};
            mul_b = {1'b0, y_op};
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   always_comb begin
      if (mode_ff == MODE_VEC) begin
         case (k_ff)
            2'd0:    y_op = f2_ff;
            2'd1:    y_op = f1_ff;
            default: y_op = term_type'(1);
         endcase
      end else begin
         y_op = rd_b;
      end
   end

   // identity into bank 0, then the companion matrix into the base region
   always_comb begin
      if (!init_sel_ff) begin
         init_val = (i_ff == j_ff) ? term_type'(1) : term_type'(0);
      end else begin
         case (i_ff)
            2'd0: begin
               case (j_ff)
                  2'd0:    init_val = a_ff;
                  2'd1:    init_val = b_ff;
                  default: init_val = c_ff;
               endcase
            end
            2'd1:    init_val = (j_ff == 2'd0) ? term_type'(1) : term_type'(0);
            default: init_val = (j_ff == IDX_LAST) ? term_type'(1) : term_type'(0);
         endcase
      end
   end

   assign r_small = (r_ff < {1'b0, TERM_MOD});
   assign acc_base = (k_ff == 2'd0) ? term_type'(0) : sum_ff;
   assign acc_sum = {1'b0, acc_base} + r_ff;
   assign acc_res = (acc_sum >= {1'b0, TERM_MOD}) ? VAL_W'(acc_sum - {1'b0, TERM_MOD})
                                                  : VAL_W'(acc_sum);

   assign raddr_a = {1'b0, bank_ff, i_ff, k_ff};
   assign raddr_b = (mode_ff == MODE_MUL) ? {REG_BASE, k_ff, j_ff}
                                          : {1'b0, bank_ff, k_ff, j_ff};

   assign ram_we = (state_ff == S_INIT) ||
                   ((state_ff == S_FIX) && r_small && (k_ff == IDX_LAST) &&
                    (mode_ff != MODE_VEC));
   assign ram_waddr = (state_ff == S_INIT)
                    ? {(init_sel_ff ? REG_BASE : REG_BANK0), i_ff, j_ff}
                    : {1'b0, ~bank_ff, i_ff, j_ff};
   assign ram_wdata = (state_ff == S_INIT) ? init_val : acc_res;

   lrmp_ram #(
      .WIDTH (VAL_W),
      .DEPTH (RAM_DEPTH)
   ) u_mat_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      bank_in      = bank_ff;
      init_sel_in  = init_sel_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      bit_in       = bit_ff;
      ex_in        = ex_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      f1_in        = f1_ff;
      f2_in        = f2_ff;
      s_in         = s_ff;
      q_in         = q_ff;
      qm_in        = qm_ff;
      r_in         = r_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_value_in = out_value_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               a_in  = reduce_once(req_bus.coef_prev);
               b_in  = reduce_once(req_bus.coef_prev2);
               c_in  = reduce_once(req_bus.addend);
               f1_in = f1_red;
               f2_in = f2_red;
               if (n_word[INDEX_BITS-1:1] == '0) begin
                  sum_in   = f1_red;
                  state_in = S_DONE;
               end else if (n_word == INDEX_BITS'(2)) begin
                  sum_in   = f2_red;
                  state_in = S_DONE;
               end else begin
                  ex_in       = n_word - INDEX_BITS'(2);
                  i_in        = 2'd0;
                  j_in        = 2'd0;
                  init_sel_in = 1'b0;
                  state_in    = S_INIT;
               end
            end
         end
         S_INIT: begin
            if (j_ff != IDX_LAST) begin
               j_in = j_ff + 2'd1;
            end else begin
               j_in = 2'd0;
               if (i_ff != IDX_LAST) begin
                  i_in = i_ff + 2'd1;
               end else begin
                  i_in = 2'd0;
                  if (!init_sel_ff) begin
                     init_sel_in = 1'b1;
                  end else begin
                     mode_in  = MODE_SQR;
                     bank_in  = 1'b0;
                     k_in     = 2'd0;
                     bit_in   = BIT_W'(INDEX_BITS - 1);
                     state_in = S_RD;
                  end
               end
            end
         end
         S_RD: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            s_in     = mul_p[S_W-1:0];
            state_in = S_QEST;
         end
         S_QEST: begin
            q_in     = mul_p[PROD_W-1:BARRETT_HI];
            state_in = S_QM;
         end
         S_QM: begin
            qm_in    = mul_p[S_W-1:0];
            state_in = S_SUB;
         end
         S_SUB: begin
            // quotient estimate is at most two short, remainder stays below 3m
            r_in     = RED_W'(s_ff - qm_ff);
            state_in = S_FIX;
         end
         S_FIX: begin
            if (!r_small) begin
               r_in = r_ff - {1'b0, TERM_MOD};
            end else begin
               sum_in = acc_res;
               if (k_ff != IDX_LAST) begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_RD;
               end else begin
                  k_in = 2'd0;
                  if (mode_ff == MODE_VEC) begin
                     state_in = S_DONE;
                  end else if (j_ff != IDX_LAST) begin
                     j_in     = j_ff + 2'd1;
                     state_in = S_RD;
                  end else if (i_ff != IDX_LAST) begin
                     j_in     = 2'd0;
                     i_in     = i_ff + 2'd1;
                     state_in = S_RD;
                  end else begin
                     // matrix product finished, result bank becomes the power
                     j_in     = 2'd0;
                     i_in     = 2'd0;
                     bank_in  = ~bank_ff;
                     state_in = S_RD;
                     if ((mode_ff == MODE_SQR) && ex_ff[bit_ff]) begin
                        mode_in = MODE_MUL;
                     end else if (bit_ff == '0) begin
                        mode_in = MODE_VEC;
                     end else begin
                        bit_in  = bit_ff - BIT_W'(1);
                        mode_in = MODE_SQR;
                     end
                  end
               end
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               out_valid_in = 1'b1;
               out_value_in = sum_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      mode_ff      <= mode_in;
      bank_ff      <= bank_in;
      init_sel_ff  <= init_sel_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      bit_ff       <= bit_in;
      ex_ff        <= ex_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      f1_ff        <= f1_in;
      f2_ff        <= f2_in;
      s_ff         <= s_in;
      q_ff         <= q_in;
      qm_ff        <= qm_in;
      r_ff         <= r_in;
      sum_ff       <= sum_in;
      out_value_ff <= out_value_in;
   end

   a_barrett_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIX) && ($past(state_ff) == S_SUB) |-> (r_ff < TERM_MOD_X3))
      else $error("barrett remainder out of range");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_value_ff < TERM_MOD))
      else $error("result word not reduced");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("block idle right after accepting a word");

   a_no_source_overwrite: assert property (@(posedge clock) disable iff (reset)
      ram_we && (state_ff == S_FIX) |->
         (ram_waddr[ADDR_W-1:ADDR_W-2] != {1'b0, bank_ff}) &&
         (ram_waddr[ADDR_W-1:ADDR_W-2] != REG_BASE))
      else $error("matrix product writes into its own source");

endmodule

// ===== hdl/lrmp_ram.sv =====
// generic ram, one write port and two registered read ports
module lrmp_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end

endmodule
